/* design/fba_pkg.sv */
// fba_pkg: shared types, constants and command/status codes for the frame bitmap allocator.
// No dependencies.
package fba_pkg;

  localparam int NumFrames = 65536;
  localparam int WordBits  = 64;
  localparam int MaxRun    = 1024;
  localparam int WordCount = NumFrames / WordBits;
  localparam int AddrW     = $clog2(WordCount);
  localparam int BitW      = $clog2(WordBits);
  localparam int FrameW    = 17;

  localparam logic [2:0] CMD_ALLOC_ONE = 3'd0;
  localparam logic [2:0] CMD_ALLOC_RUN = 3'd1;
  localparam logic [2:0] CMD_FREE_ONE  = 3'd2;
  localparam logic [2:0] CMD_FREE_RUN  = 3'd3;
  localparam logic [2:0] CMD_RSV_RUN   = 3'd4;
  localparam logic [2:0] CMD_QUERY     = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_CHK, S_WR_RD, S_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [WordBits-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // Mask of bits [lo, hi] inclusive within one word.
  function automatic logic [WordBits-1:0] span_mask(input logic [BitW-1:0] lo,
                                                    input logic [BitW-1:0] hi);
    logic [WordBits-1:0] m;
    m = '0;
    for (int k = 0; k < WordBits; k++)
      m[k] = (k >= int'(lo)) && (k <= int'(hi));
    return m;
  endfunction

endpackage

/* design/fba_ram.sv */
// fba_ram: single-port-write, single-port-read bitmap memory, registered read.
// Depends on fba_pkg.
module fba_ram (
  input  logic                clk,
  input  fba_pkg::mem_req_t   req,
  output logic [fba_pkg::WordBits-1:0] rdata
);
  logic [fba_pkg::WordBits-1:0] mem [fba_pkg::WordCount];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    if (req.re) rdata <= mem[req.raddr];
  end
endmodule

/* design/frame_bitmap_allocator_core.sv */
// frame_bitmap_allocator_core: top level of the bitmap frame allocator.
// Depends on fba_pkg and fba_ram.
//
// Bitmap allocator, one bit per frame (1 = used), held in a 1024 x 64 RAM.
// After reset a clearing pass writes all-ones to every word, during which
// in_tready is low. One command at a time: each command that passes its
// accept checks walks RAM words, each word in S_RD then S_CHK (read, then
// check and write back in the same cycle). Alloc-one scans words from 0
// until a free bit; alloc-run checks candidate starts 0, N, 2N... word by
// word, then a second pass sets the run. Free runs touch the spanned words
// (at most 17) twice (check then write); reserve runs touch them once. The
// walk ends in S_DONE, as does a command rejected at accept; the RAM's single
// read port sets the pace of the walk. The result sits in an output register;
// the next beat can be taken while it waits, and the core holds in its done
// state until that register is free.
module frame_bitmap_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [2:0] command, [18:3] frame_index, [29:19] run_length
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [2:0] status, [18:3] result_index, [19] is_free
);
  localparam int AW = fba_pkg::AddrW;
  localparam int BW = fba_pkg::BitW;
  localparam int WB = fba_pkg::WordBits;
  localparam int FW = fba_pkg::FrameW;

  fba_pkg::state_t st_r, st_nxt;
  fba_pkg::mem_req_t req;
  logic [WB-1:0] rdata;

  logic [16:0] total_r;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [FW-1:0] lim_r, lim_nxt;      // effective limit
  logic [FW-1:0] first_r, first_nxt;  // run start
  logic [FW-1:0] last_r, last_nxt;    // run end inclusive
  logic [11:0] len_r, len_nxt;
  logic [AW:0] wa_r, wa_nxt;          // current word
  logic        pass2_r, pass2_nxt;    // write pass of a checked run
  logic [2:0]  status_r, status_nxt;
  logic [15:0] res_r, res_nxt;
  logic        free_r, free_nxt;
  logic        ov_r, ov_nxt;

  fba_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  // Word bounds of the current run span.
  logic [AW:0] w_first, w_last;
  logic [BW-1:0] lo_b, hi_b;
  logic [WB-1:0] mask, limmask;
  logic [FW-1:0] word_base;
  assign w_first = first_r[FW-1:BW];
  assign w_last  = last_r[FW-1:BW];
  assign lo_b = (wa_r == w_first) ? first_r[BW-1:0] : '0;
  assign hi_b = (wa_r == w_last) ? last_r[BW-1:0] : '1;
  assign mask = fba_pkg::span_mask(lo_b, hi_b);
  assign word_base = {wa_r, {BW{1'b0}}};
  // Bits below the limit within the current word.
  always_comb begin
    for (int k = 0; k < WB; k++)
      limmask[k] = ({1'b0, word_base} + (FW+1)'(k)) < {1'b0, lim_r};
  end

  // Lowest free bit in the word (priority encode).
  logic [WB-1:0] freeb;
  logic          any_free;
  logic [BW-1:0] first_free;
  assign freeb = ~rdata & limmask;
  assign any_free = |freeb;
  always_comb begin
    first_free = '0;
    for (int k = WB - 1; k >= 0; k--)
      if (freeb[k]) first_free = BW'(k);
  end

  logic [2:0]  i_cmd;
  logic [15:0] i_fi;
  logic [10:0] i_len;
  assign i_cmd = in_tdata[2:0];
  assign i_fi  = in_tdata[18:3];
  assign i_len = in_tdata[29:19];

  logic [FW:0] run_end; // first + len, one past
  assign run_end = {1'b0, first_r} + (FW+1)'(len_r);

  always_comb begin
    st_nxt = st_r; cmd_nxt = cmd_r; lim_nxt = lim_r; first_nxt = first_r;
    last_nxt = last_r; len_nxt = len_r; wa_nxt = wa_r; pass2_nxt = pass2_r;
    status_nxt = status_r; res_nxt = res_r; free_nxt = free_r; ov_nxt = ov_r;
    req = '0;
    in_tready = 1'b0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (st_r)
      fba_pkg::S_CLEAR: begin
        req.we = 1'b1; req.waddr = wa_r[AW-1:0]; req.wdata = '1;
        wa_nxt = wa_r + 1'b1;
        if (wa_r[AW-1:0] == '1) begin
          st_nxt = fba_pkg::S_IDLE; wa_nxt = '0;
        end
      end
      fba_pkg::S_IDLE: begin
        // a pending result does not block: S_DONE waits for the output register
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt = i_cmd;
          lim_nxt = (total_r > 17'(fba_pkg::NumFrames)) ? FW'(fba_pkg::NumFrames)
                                                       : FW'(total_r);
          len_nxt = {1'b0, i_len};
          status_nxt = fba_pkg::ST_OK; res_nxt = '0; free_nxt = 1'b0;
          pass2_nxt = 1'b0;
          st_nxt = fba_pkg::S_RD;
          unique case (i_cmd) inside
            fba_pkg::CMD_ALLOC_ONE: begin
              first_nxt = '0; wa_nxt = '0;
              if (lim_nxt == '0) begin
                status_nxt = fba_pkg::ST_NO_SPACE; st_nxt = fba_pkg::S_DONE;
              end
            end
            fba_pkg::CMD_ALLOC_RUN: begin
              first_nxt = '0; last_nxt = FW'(i_len) - 1'b1; wa_nxt = '0;
              if (i_len == '0 || i_len > 11'(fba_pkg::MaxRun)) begin
                status_nxt = fba_pkg::ST_BAD_LEN; st_nxt = fba_pkg::S_DONE;
              end else if (FW'(i_len) > lim_nxt) begin
                status_nxt = fba_pkg::ST_NO_SPACE; st_nxt = fba_pkg::S_DONE;
              end
            end
            fba_pkg::CMD_FREE_ONE, fba_pkg::CMD_QUERY: begin
              first_nxt = FW'(i_fi); last_nxt = FW'(i_fi);
              wa_nxt = (AW+1)'(i_fi[15:BW]);
              if (FW'(i_fi) >= lim_nxt) begin
                status_nxt = fba_pkg::ST_RANGE; st_nxt = fba_pkg::S_DONE;
              end
            end
            fba_pkg::CMD_FREE_RUN, fba_pkg::CMD_RSV_RUN: begin
              first_nxt = FW'(i_fi); last_nxt = FW'(i_fi) + FW'(i_len) - 1'b1;
              wa_nxt = (AW+1)'(i_fi[15:BW]);
              if (i_len == '0 || i_len > 11'(fba_pkg::MaxRun)) begin
                status_nxt = fba_pkg::ST_BAD_LEN; st_nxt = fba_pkg::S_DONE;
              end else if (FW'(i_fi) + FW'(i_len) > lim_nxt) begin
                status_nxt = fba_pkg::ST_RANGE; st_nxt = fba_pkg::S_DONE;
              end else if (i_cmd == fba_pkg::CMD_RSV_RUN) begin
                pass2_nxt = 1'b1;
              end
            end
            default: begin
              status_nxt = fba_pkg::ST_RANGE; st_nxt = fba_pkg::S_DONE;
            end
          endcase
        end
      end
      fba_pkg::S_RD: begin
        req.re = 1'b1; req.raddr = wa_r[AW-1:0];
        st_nxt = fba_pkg::S_CHK;
      end
      fba_pkg::S_CHK: begin
        st_nxt = fba_pkg::S_RD;
        if (pass2_r) begin
          // write pass: set or clear the span bits
          req.we = 1'b1; req.waddr = wa_r[AW-1:0];
          req.wdata = (cmd_r == fba_pkg::CMD_FREE_RUN) ? (rdata & ~mask) : (rdata | mask);
          if (wa_r == w_last) st_nxt = fba_pkg::S_DONE;
          else wa_nxt = wa_r + 1'b1;
          if (cmd_r == fba_pkg::CMD_ALLOC_RUN) res_nxt = first_r[15:0];
        end else begin
          unique case (cmd_r)
            fba_pkg::CMD_ALLOC_ONE: begin
              if (any_free) begin
                req.we = 1'b1; req.waddr = wa_r[AW-1:0];
                req.wdata = rdata | (WB'(1) << first_free);
                res_nxt = 16'({wa_r[AW-1:0], first_free});
                st_nxt = fba_pkg::S_DONE;
              end else if (word_base + FW'(WB) >= lim_r) begin
                status_nxt = fba_pkg::ST_NO_SPACE; st_nxt = fba_pkg::S_DONE;
              end else wa_nxt = wa_r + 1'b1;
            end
            fba_pkg::CMD_QUERY: begin
              free_nxt = ~rdata[first_r[BW-1:0]];
              st_nxt = fba_pkg::S_DONE;
            end
            fba_pkg::CMD_FREE_ONE: begin
              if (!rdata[first_r[BW-1:0]]) status_nxt = fba_pkg::ST_NOT_ALLOC;
              else begin
                req.we = 1'b1; req.waddr = wa_r[AW-1:0];
                req.wdata = rdata & ~(WB'(1) << first_r[BW-1:0]);
              end
              st_nxt = fba_pkg::S_DONE;
            end
            fba_pkg::CMD_FREE_RUN: begin
              if ((~rdata & mask) != '0) begin
                status_nxt = fba_pkg::ST_NOT_ALLOC; st_nxt = fba_pkg::S_DONE;
              end else if (wa_r == w_last) begin
                pass2_nxt = 1'b1; wa_nxt = w_first;
              end else wa_nxt = wa_r + 1'b1;
            end
            default: begin // alloc run: check candidate span
              if ((rdata & mask) != '0) begin
                // next candidate
                first_nxt = first_r + FW'(len_r);
                last_nxt = last_r + FW'(len_r);
                wa_nxt = (AW+1)'(first_nxt[FW-1:BW]);
                if ({1'b0, last_nxt} >= {1'b0, lim_r} || run_end[FW]) begin
                  status_nxt = fba_pkg::ST_NO_SPACE; st_nxt = fba_pkg::S_DONE;
                end
              end else if (wa_r == w_last) begin
                pass2_nxt = 1'b1; wa_nxt = w_first;
              end else wa_nxt = wa_r + 1'b1;
            end
          endcase
        end
      end
      fba_pkg::S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; st_nxt = fba_pkg::S_IDLE;
        end
      end
      default: st_nxt = fba_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= fba_pkg::S_CLEAR;
      wa_r <= '0;
      ov_r <= 1'b0;
      total_r <= 17'd65536;
      pass2_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      wa_r <= wa_nxt;
      ov_r <= ov_nxt;
      pass2_r <= pass2_nxt;
      if (cfg_we) total_r <= cfg_wdata;
    end
    cmd_r <= cmd_nxt; lim_r <= lim_nxt; first_r <= first_nxt; last_r <= last_nxt;
    len_r <= len_nxt; status_r <= status_nxt; res_r <= res_nxt; free_r <= free_nxt;
  end

  // Result register holds the finished item until taken.
  logic [2:0]  o_st_r;
  logic [15:0] o_res_r;
  logic        o_free_r;
  always_ff @(posedge clk) begin
    if (st_r == fba_pkg::S_DONE && st_nxt == fba_pkg::S_IDLE) begin
      o_st_r <= status_nxt; o_res_r <= res_nxt; o_free_r <= free_nxt;
    end
  end
  assign out_tvalid = ov_r;
  assign out_tdata = {4'b0, o_free_r, o_res_r, o_st_r};

  // A stalled result beat stays put until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result beat changed while stalled");
  // No acceptance during the clearing pass.
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == fba_pkg::S_CLEAR) |-> !in_tready) else $error("ready during clear");
  // Failed commands report index zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2:0] != fba_pkg::ST_OK) |-> out_tdata[18:3] == '0)
    else $error("nonzero index on failure");
endmodule

/* tb/tb_frame_bitmap_allocator_core.sv */
// Self-checking testbench for frame_bitmap_allocator_core: a bitmap predictor
// checks every result beat. Needs fba_pkg and the RTL of the core.
module tb_frame_bitmap_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 200000;   // cycles with no beat in either direction
  localparam int HoldCycles = 3000;     // long receiver back-off

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] start_idx;
    logic        frame_free;
  } alloc_reply_t;

  // Bitmap predictor plus queue of replies still owed by the core.
  class frame_alloc_tracker;
    bit           used_map[fba_pkg::NumFrames];
    int unsigned  frame_cap;
    alloc_reply_t owed[$];
    int           mismatches;

    function void init();
      foreach (used_map[k]) used_map[k] = 1'b1;   // everything reserved at reset
      frame_cap  = 65536;
      mismatches = 0;
    endfunction

    function void set_cap(int unsigned v);
      frame_cap = v;
    endfunction

    function int unsigned cap();
      return (frame_cap > fba_pkg::NumFrames) ? fba_pkg::NumFrames : frame_cap;
    endfunction

    function bit span_free(int unsigned first, int unsigned n);
      for (int unsigned j = 0; j < n; j++)
        if (first + j >= fba_pkg::NumFrames || used_map[first + j]) return 1'b0;
      return 1'b1;
    endfunction

    function void span_mark(int unsigned first, int unsigned n, bit v);
      for (int unsigned j = 0; j < n; j++)
        if (first + j < fba_pkg::NumFrames) used_map[first + j] = v;
    endfunction

    // Apply one accepted command and queue the reply it must produce.
    function void note_command(logic [2:0] cmd, logic [15:0] fi, logic [10:0] n);
      int unsigned  lim;
      int unsigned  len;
      int unsigned  base;
      bit           len_bad;
      alloc_reply_t r;
      lim     = cap();
      len     = n;
      base    = fi;
      len_bad = (len == 0) || (len > fba_pkg::MaxRun);
      r       = '{fba_pkg::ST_OK, 16'd0, 1'b0};
      case (cmd) inside
        fba_pkg::CMD_ALLOC_ONE: begin
          r.status = fba_pkg::ST_NO_SPACE;
          for (int unsigned i = 0; i < lim; i++)
            if (!used_map[i]) begin
              used_map[i] = 1'b1;
              r.status    = fba_pkg::ST_OK;
              r.start_idx = i[15:0];
              break;
            end
        end
        fba_pkg::CMD_ALLOC_RUN: begin
          if (len_bad) r.status = fba_pkg::ST_BAD_LEN;
          else begin
            r.status = fba_pkg::ST_NO_SPACE;
            // aligned candidates only; a run crossing the cap never fits
            for (int unsigned i = 0; i < lim && i + len <= lim; i += len)
              if (span_free(i, len)) begin
                span_mark(i, len, 1'b1);
                r.status    = fba_pkg::ST_OK;
                r.start_idx = i[15:0];
                break;
              end
          end
        end
        fba_pkg::CMD_FREE_ONE: begin
          if (base >= lim)          r.status = fba_pkg::ST_RANGE;
          else if (!used_map[base]) r.status = fba_pkg::ST_NOT_ALLOC;
          else                      used_map[base] = 1'b0;
        end
        fba_pkg::CMD_FREE_RUN, fba_pkg::CMD_RSV_RUN: begin
          if (len_bad)                          r.status = fba_pkg::ST_BAD_LEN;
          else if (base + len > lim)            r.status = fba_pkg::ST_RANGE;
          else if (cmd == fba_pkg::CMD_RSV_RUN) span_mark(base, len, 1'b1);
          else begin
            // all-or-nothing: one free frame in the run rejects it
            bit any_free;
            any_free = 1'b0;
            for (int unsigned j = 0; j < len; j++)
              if (!used_map[base + j]) any_free = 1'b1;
            if (any_free) r.status = fba_pkg::ST_NOT_ALLOC;
            else          span_mark(base, len, 1'b0);
          end
        end
        fba_pkg::CMD_QUERY: begin
          if (base >= lim) r.status = fba_pkg::ST_RANGE;
          else             r.frame_free = !used_map[base];
        end
        default: r.status = fba_pkg::ST_RANGE;
      endcase
      owed.push_back(r);
    endfunction

    function void check_result(logic [23:0] tdata);
      alloc_reply_t exp_r;
      alloc_reply_t got;
      got = '{tdata[2:0], tdata[18:3], tdata[19]};
      if (owed.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, tdata);
        mismatches++;
        return;
      end
      exp_r = owed.pop_front();
      if (got.status !== exp_r.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, exp_r.status, got.status);
        mismatches++;
      end
      if (got.start_idx !== exp_r.start_idx) begin
        $display("%0t: result_index mismatch, expected %0d, actual %0d",
                 $time, exp_r.start_idx, got.start_idx);
        mismatches++;
      end
      if (got.frame_free !== exp_r.frame_free) begin
        $display("%0t: is_free mismatch, expected %0d, actual %0d",
                 $time, exp_r.frame_free, got.frame_free);
        mismatches++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [16:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [2:0] command, [18:3] frame_index, [29:19] run_length
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [2:0] status, [18:3] result_index, [19] is_free

  frame_alloc_tracker tracker;
  bit in_idle_on;        // sender may insert gaps
  bit out_idle_on;       // receiver may stall at random
  bit hold_req;          // ask receiver for a long back-off
  int quiet_cycles;

  frame_bitmap_allocator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 8 ns clock
  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // Result side: check every accepted beat, stall at random or on request.
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
      if (hold_req && hold_left == 0) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(out_idle_on && $urandom_range(99) < 14);
      end
    end
  end

  // Watchdog: any beat in either direction restarts the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // One command beat; returns once the core has taken it.
  task automatic send_cmd(logic [2:0] cmd, logic [15:0] fi, logic [10:0] n);
    while (in_idle_on && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, n, fi, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_command(cmd, fi, n);
  endtask

  // Sender stops until every owed reply is back, then a short settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cap(int unsigned v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[16:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.set_cap(v);
  endtask

  // Cap-wide reserve then free so the whole window starts out free.
  task automatic open_window(int unsigned lim);
    for (int unsigned s = 0; s < lim; s += fba_pkg::MaxRun) begin
      int unsigned len;
      len = (lim - s > fba_pkg::MaxRun) ? fba_pkg::MaxRun : lim - s;
      send_cmd(fba_pkg::CMD_RSV_RUN, s[15:0], len[10:0]);
      send_cmd(fba_pkg::CMD_FREE_RUN, s[15:0], len[10:0]);
    end
  endtask

  // Random traffic inside a small window; alloc runs stay cheap here.
  task automatic random_burst(int unsigned lim, int count);
    for (int k = 0; k < count; k++) begin
      logic [2:0]  cmd;
      logic [15:0] fi;
      logic [10:0] n;
      int          pick;
      pick = $urandom_range(99);
      if      (pick < 20) cmd = fba_pkg::CMD_ALLOC_ONE;
      else if (pick < 35) cmd = fba_pkg::CMD_ALLOC_RUN;
      else if (pick < 55) cmd = fba_pkg::CMD_FREE_ONE;
      else if (pick < 70) cmd = fba_pkg::CMD_FREE_RUN;
      else if (pick < 80) cmd = fba_pkg::CMD_RSV_RUN;
      else if (pick < 95) cmd = fba_pkg::CMD_QUERY;
      else                cmd = 3'($urandom_range(6, 7));
      if ($urandom_range(99) < 85) fi = 16'($urandom_range(0, lim + 8));
      else                         fi = 16'($urandom);
      pick = $urandom_range(99);
      if      (pick < 80) n = 11'($urandom_range(1, 16));
      else if (pick < 90) n = 11'($urandom_range(17, fba_pkg::MaxRun));
      else                n = 11'($urandom);   // zero and oversize lengths too
      send_cmd(cmd, fi, n);
    end
  endtask

  initial begin
    int unsigned caps[4];
    tracker = new();
    tracker.init();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    hold_req    = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass at the full cap; the core is still clearing its RAM.
    write_cap(65536);
    send_cmd(fba_pkg::CMD_QUERY,     16'd0,     11'd0);
    send_cmd(fba_pkg::CMD_QUERY,     16'd65535, 11'd0);
    send_cmd(fba_pkg::CMD_FREE_ONE,  16'd0,     11'd0);
    send_cmd(fba_pkg::CMD_FREE_ONE,  16'd0,     11'd0);      // already free
    send_cmd(fba_pkg::CMD_ALLOC_ONE, 16'd0,     11'd0);
    send_cmd(fba_pkg::CMD_ALLOC_RUN, 16'd0,     11'd0);      // zero length
    send_cmd(fba_pkg::CMD_ALLOC_RUN, 16'd0,     11'd1025);   // just over max run
    send_cmd(fba_pkg::CMD_FREE_RUN,  16'd0,     11'd2047);
    send_cmd(fba_pkg::CMD_FREE_RUN,  16'd1024,  11'd1024);
    send_cmd(fba_pkg::CMD_FREE_RUN,  16'd2000,  11'd10);     // already free: rejected
    send_cmd(fba_pkg::CMD_ALLOC_RUN, 16'd0,     11'd1024);
    send_cmd(fba_pkg::CMD_ALLOC_RUN, 16'd0,     11'd1024);   // nothing left
    send_cmd(fba_pkg::CMD_FREE_ONE,  16'd65535, 11'd0);
    send_cmd(fba_pkg::CMD_QUERY,     16'd65535, 11'd0);
    send_cmd(fba_pkg::CMD_FREE_RUN,  16'd65535, 11'd2);      // crosses the cap
    send_cmd(fba_pkg::CMD_RSV_RUN,   16'd65535, 11'd1);
    send_cmd(fba_pkg::CMD_RSV_RUN,   16'd0,     11'd1024);   // reserving used frames is fine
    send_cmd(3'd6,                   16'hffff,  11'h7ff);
    send_cmd(3'd7,                   16'd0,     11'd1);
    send_cmd(fba_pkg::CMD_ALLOC_ONE, 16'd0,     11'd0);      // full scan, no space
    send_cmd(fba_pkg::CMD_FREE_RUN,  16'd64512, 11'd1024);
    send_cmd(fba_pkg::CMD_ALLOC_RUN, 16'd0,     11'd1024);   // last aligned slot
    drain();

    // Zero cap: allocations find no space, index commands are out of range, bad lengths apart.
    write_cap(0);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    random_burst(0, 12);
    drain();

    // Small windows, one of them the smallest useful cap.
    caps[0] = 1;
    caps[1] = 64;
    caps[2] = 2048;
    caps[3] = $urandom_range(65, 2000);
    for (int p = 0; p < 4; p++) begin
      write_cap(caps[p]);
      open_window(caps[p]);
      if (p == 2) begin
        // back-pressure: receiver backs off while commands keep coming
        hold_req = 1'b1;
        random_burst(caps[p], 40);
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        random_burst(caps[p], 40);    // stretch with no gaps at all
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        random_burst(caps[p], 30);
      end else begin
        random_burst(caps[p], 95);
      end
      drain();
    end

    // Full cap again: whole index range, alloc runs kept long to bound scans.
    write_cap(65536);
    for (int k = 0; k < 70; k++) begin
      logic [2:0] cmd;
      int         pick;
      pick = $urandom_range(99);
      if      (pick < 15) cmd = fba_pkg::CMD_ALLOC_ONE;
      else if (pick < 25) cmd = fba_pkg::CMD_ALLOC_RUN;
      else if (pick < 45) cmd = fba_pkg::CMD_FREE_ONE;
      else if (pick < 60) cmd = fba_pkg::CMD_FREE_RUN;
      else if (pick < 70) cmd = fba_pkg::CMD_RSV_RUN;
      else                cmd = fba_pkg::CMD_QUERY;
      if (cmd == fba_pkg::CMD_ALLOC_RUN)
        send_cmd(cmd, 16'($urandom), 11'($urandom_range(512, fba_pkg::MaxRun)));
      else
        send_cmd(cmd, 16'($urandom), 11'($urandom_range(1, 64)));
    end
    drain();

    repeat (100) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
